// File: rtl/ctds_pkg.sv
// Shared types and constants for the C top-level declaration splitter.
// No dependencies; used by ctds_top through scoped names.
`default_nettype none

package ctds_pkg;

    localparam int INDEX_BITS = 20;
    localparam int LINE_BITS  = 16;
    localparam int NEST_BITS  = 16;
    localparam int KIND_BITS  = 5;
    localparam int CAT_BITS   = 4;

    // Result queue; every item may push two results
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 80;

    typedef enum logic [KIND_BITS-1:0] {
        TK_OTHER     = 5'd0,
        TK_EOF       = 5'd1,
        TK_DEFINE    = 5'd2,
        TK_PRAGMA    = 5'd3,
        TK_INCLUDE   = 5'd4,
        TK_ERROR_DIR = 5'd5,
        TK_IF        = 5'd6,
        TK_IFDEF     = 5'd7,
        TK_IFNDEF    = 5'd8,
        TK_ENDIF     = 5'd9,
        TK_TYPEDEF   = 5'd10,
        TK_ENUM      = 5'd11,
        TK_STRUCT    = 5'd12,
        TK_IDENT     = 5'd13,
        TK_LPAREN    = 5'd14,
        TK_EQ        = 5'd15,
        TK_LBRACE    = 5'd16,
        TK_RBRACE    = 5'd17,
        TK_SEMICOLON = 5'd18,
        TK_BACKSLASH = 5'd19
    } token_kind_t;

    typedef enum logic [CAT_BITS-1:0] {
        CAT_DEFINE      = 4'd0,
        CAT_PRAGMA      = 4'd1,
        CAT_INCLUDE     = 4'd2,
        CAT_IF_BLOCK    = 4'd3,
        CAT_TYPEDEF     = 4'd4,
        CAT_ENUM        = 4'd5,
        CAT_STRUCT      = 4'd6,
        CAT_FUNCTION    = 4'd7,
        CAT_GLOBAL      = 4'd8,
        CAT_UNEXPECTED  = 4'd9,
        CAT_END_OF_FILE = 4'd10
    } category_t;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_LINE,
        MODE_IF,
        MODE_TD_FIRST,
        MODE_TD_BODY,
        MODE_TD_END,
        MODE_SE_IDENT,
        MODE_SE_SKIP,
        MODE_SE_BODY,
        MODE_SE_ENDCHAR,
        MODE_SE_TAIL,
        MODE_ID_PRE,
        MODE_ID_POST,
        MODE_GL_BODY,
        MODE_FN_BODY
    } mode_t;

    typedef struct packed {
        category_t             category;
        logic [INDEX_BITS-1:0] start_index;
        logic [LINE_BITS-1:0]  start_line;
        logic [INDEX_BITS-1:0] end_index;
        logic [LINE_BITS-1:0]  close_line;
        logic                  last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/c_toplevel_declaration_splitter_top.sv
// Top level of the C top-level declaration splitter: token decode, record
// state machine and a small result queue. Depends on ctds_pkg.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: token_kind, token_line, token_index
// m_axis    out  m_tvalid/m_tready  m_tdata: record fields, m_tlast: last
//
// Each token is decoded in the cycle it is accepted; its zero, one or two
// records enter a four-entry result queue and leave one per cycle while
// m_tready is high. A token is taken every cycle while the queue has room
// for two records, so tokens that make at most one record stream at one per
// cycle while m_tready is high. After reset the block is idle and the queue
// empty. A stalled output only holds back input once two more records do not fit.

module c_toplevel_declaration_splitter_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [4:0] token_kind, [20:5] token_line, [40:21] token_index, rest zero
    input  wire logic [ctds_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [3:0] category, [23:4] start_index, [39:24] start_line,
    // [59:40] end_index, [75:60] close_line, rest zero
    output logic [ctds_pkg::OUT_DATA_BITS-1:0]      m_tdata,
    output logic                                    m_tlast
);

    localparam int IB = ctds_pkg::INDEX_BITS;
    localparam int LB = ctds_pkg::LINE_BITS;
    localparam int NB = ctds_pkg::NEST_BITS;
    localparam int KB = ctds_pkg::KIND_BITS;

    logic [KB-1:0] kind;
    logic [LB-1:0] line;
    logic [IB-1:0] idx;

    assign kind = s_tdata[KB-1:0];
    assign line = s_tdata[KB+LB-1:KB];
    assign idx  = s_tdata[KB+LB+IB-1:KB+LB];

    // Record state
    ctds_pkg::mode_t     mode_reg,     mode_next;
    logic [NB-1:0]       nest_reg,     nest_next;
    logic [IB-1:0]       rs_index_reg, rs_index_next;
    logic [LB-1:0]       rs_line_reg,  rs_line_next;
    logic [LB-1:0]       tracked_reg,  tracked_next;
    logic [IB-1:0]       prev_index_reg;
    logic [LB-1:0]       prev_line_reg;
    ctds_pkg::category_t pending_reg,  pending_next;
    logic                halted_reg,   halted_next;

    // Result queue
    ctds_pkg::result_t                fifo_reg [ctds_pkg::FIFO_DEPTH];
    logic [ctds_pkg::PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ctds_pkg::CNT_BITS-1:0]    count_reg;

    logic s_accept, m_accept;

    // Decode
    logic do_top, top_bad, eof_hit, fail_hit;
    logic open_v;
    ctds_pkg::category_t open_cat;
    logic [IB-1:0]       open_ei;
    logic [LB-1:0]       open_el;
    logic                tok_v;
    ctds_pkg::category_t tok_cat;
    logic [1:0]          n_res;
    ctds_pkg::result_t   res0, res1, open_rec, tok_rec;

    assign s_tready = (count_reg <= ctds_pkg::CNT_BITS'(ctds_pkg::FIFO_DEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_accept = m_tvalid && m_tready;

    // Tokens that may not open a top-level record
    always_comb
    begin
        unique case (kind)
            ctds_pkg::TK_EOF, ctds_pkg::TK_DEFINE, ctds_pkg::TK_PRAGMA,
            ctds_pkg::TK_INCLUDE, ctds_pkg::TK_ERROR_DIR, ctds_pkg::TK_IF,
            ctds_pkg::TK_IFDEF, ctds_pkg::TK_IFNDEF, ctds_pkg::TK_TYPEDEF,
            ctds_pkg::TK_ENUM, ctds_pkg::TK_STRUCT, ctds_pkg::TK_IDENT:
                top_bad = 1'b0;
            default:
                top_bad = 1'b1;
        endcase
    end

    // Which modes hand the token back to top-level handling, and token records
    always_comb
    begin
        do_top   = 1'b0;
        eof_hit  = 1'b0;
        fail_hit = 1'b0;
        if (!halted_reg)
        begin
            unique case (mode_reg)
                ctds_pkg::MODE_LINE:
                    do_top = (kind == ctds_pkg::TK_EOF) || (line != tracked_reg);
                ctds_pkg::MODE_TD_FIRST:
                begin
                    do_top   = (kind == ctds_pkg::TK_ENUM) || (kind == ctds_pkg::TK_STRUCT);
                    fail_hit = !do_top && (kind != ctds_pkg::TK_IDENT);
                end
                ctds_pkg::MODE_TD_END:
                    do_top = 1'b1;
                ctds_pkg::MODE_SE_IDENT:
                    fail_hit = (kind != ctds_pkg::TK_IDENT);
                ctds_pkg::MODE_IF, ctds_pkg::MODE_TD_BODY, ctds_pkg::MODE_SE_SKIP,
                ctds_pkg::MODE_SE_BODY, ctds_pkg::MODE_SE_ENDCHAR,
                ctds_pkg::MODE_SE_TAIL, ctds_pkg::MODE_ID_PRE,
                ctds_pkg::MODE_ID_POST, ctds_pkg::MODE_GL_BODY,
                ctds_pkg::MODE_FN_BODY:
                    eof_hit = (kind == ctds_pkg::TK_EOF);
                default:
                    do_top = 1'b1;
            endcase
            if (do_top)
            begin
                eof_hit  = (kind == ctds_pkg::TK_EOF);
                fail_hit = top_bad;
            end
        end
    end

    // Record output: an open record is closed first, then the token record
    always_comb
    begin
        open_v   = 1'b0;
        open_cat = pending_reg;
        open_ei  = idx;
        open_el  = line;
        if (!halted_reg)
        begin
            unique case (mode_reg)
                ctds_pkg::MODE_LINE:
                begin
                    open_v  = do_top;
                    open_ei = prev_index_reg;
                    open_el = tracked_reg;
                end
                ctds_pkg::MODE_IF:
                begin
                    open_cat = ctds_pkg::CAT_IF_BLOCK;
                    if (kind == ctds_pkg::TK_EOF)
                    begin
                        open_v  = 1'b1;
                        open_ei = prev_index_reg;
                        open_el = prev_line_reg;
                    end
                    else
                    begin
                        open_v = (kind == ctds_pkg::TK_ENDIF) && (nest_reg == NB'(1));
                    end
                end
                ctds_pkg::MODE_TD_BODY:
                begin
                    open_cat = ctds_pkg::CAT_TYPEDEF;
                    open_v   = (kind == ctds_pkg::TK_EOF);
                end
                ctds_pkg::MODE_TD_END:
                begin
                    open_cat = ctds_pkg::CAT_TYPEDEF;
                    open_v   = 1'b1;
                end
                ctds_pkg::MODE_SE_SKIP, ctds_pkg::MODE_SE_BODY:
                    open_v = (kind == ctds_pkg::TK_EOF);
                ctds_pkg::MODE_SE_ENDCHAR:
                    open_v = 1'b1;
                ctds_pkg::MODE_ID_PRE, ctds_pkg::MODE_ID_POST, ctds_pkg::MODE_GL_BODY:
                begin
                    open_cat = ctds_pkg::CAT_GLOBAL;
                    if (kind == ctds_pkg::TK_EOF)
                    begin
                        open_v  = 1'b1;
                        open_ei = prev_index_reg;
                        open_el = prev_line_reg;
                    end
                    else
                    begin
                        open_v = (kind == ctds_pkg::TK_SEMICOLON);
                    end
                end
                ctds_pkg::MODE_FN_BODY:
                begin
                    open_cat = ctds_pkg::CAT_FUNCTION;
                    if (kind == ctds_pkg::TK_EOF)
                    begin
                        open_v  = 1'b1;
                        open_ei = prev_index_reg;
                        open_el = prev_line_reg;
                    end
                    else
                    begin
                        open_v = (kind == ctds_pkg::TK_RBRACE) && (nest_reg == NB'(1));
                    end
                end
                default:
                    open_v = 1'b0;
            endcase
        end
        tok_v   = eof_hit || fail_hit;
        tok_cat = fail_hit ? ctds_pkg::CAT_UNEXPECTED : ctds_pkg::CAT_END_OF_FILE;
    end

    always_comb
    begin
        open_rec = '{category: open_cat, start_index: rs_index_reg,
                     start_line: rs_line_reg, end_index: open_ei,
                     close_line: open_el, last: !tok_v};
        tok_rec  = '{category: tok_cat, start_index: idx, start_line: line,
                     end_index: idx, close_line: line, last: 1'b1};
        res0     = open_v ? open_rec : tok_rec;
        res1     = tok_rec;
        n_res    = {1'b0, open_v} + {1'b0, tok_v};
    end

    // Next state
    always_comb
    begin
        mode_next     = mode_reg;
        nest_next     = nest_reg;
        rs_index_next = rs_index_reg;
        rs_line_next  = rs_line_reg;
        tracked_next  = tracked_reg;
        pending_next  = pending_reg;
        halted_next   = halted_reg;
        if (!halted_reg)
        begin
            unique case (mode_reg)
                ctds_pkg::MODE_LINE:
                    if (!do_top && (kind == ctds_pkg::TK_BACKSLASH))
                    begin
                        tracked_next = tracked_reg + LB'(1);
                    end
                ctds_pkg::MODE_IF:
                    if ((kind == ctds_pkg::TK_IF) || (kind == ctds_pkg::TK_IFDEF)
                        || (kind == ctds_pkg::TK_IFNDEF))
                    begin
                        nest_next = (&nest_reg) ? nest_reg : nest_reg + NB'(1);
                    end
                    else if (kind == ctds_pkg::TK_ENDIF)
                    begin
                        nest_next = nest_reg - NB'(1);
                        if (nest_reg == NB'(1))
                        begin
                            mode_next = ctds_pkg::MODE_IDLE;
                        end
                    end
                ctds_pkg::MODE_TD_FIRST:
                    if (kind == ctds_pkg::TK_IDENT)
                    begin
                        mode_next = ctds_pkg::MODE_TD_BODY;
                    end
                ctds_pkg::MODE_TD_BODY:
                    if (kind == ctds_pkg::TK_SEMICOLON)
                    begin
                        mode_next = ctds_pkg::MODE_TD_END;
                    end
                ctds_pkg::MODE_SE_IDENT:
                    if (kind == ctds_pkg::TK_IDENT)
                    begin
                        rs_index_next = idx;
                        rs_line_next  = line;
                        mode_next     = ctds_pkg::MODE_SE_SKIP;
                    end
                ctds_pkg::MODE_SE_SKIP:
                begin
                    // skip the token after the name unchecked
                    nest_next = NB'(1);
                    mode_next = ctds_pkg::MODE_SE_BODY;
                end
                ctds_pkg::MODE_SE_BODY:
                    if (kind == ctds_pkg::TK_LBRACE)
                    begin
                        nest_next = (&nest_reg) ? nest_reg : nest_reg + NB'(1);
                    end
                    else if (kind == ctds_pkg::TK_RBRACE)
                    begin
                        nest_next = nest_reg - NB'(1);
                        if (nest_reg == NB'(1))
                        begin
                            mode_next = ctds_pkg::MODE_SE_ENDCHAR;
                        end
                    end
                ctds_pkg::MODE_SE_ENDCHAR:
                    mode_next = (kind == ctds_pkg::TK_SEMICOLON) ? ctds_pkg::MODE_IDLE
                                                                : ctds_pkg::MODE_SE_TAIL;
                ctds_pkg::MODE_SE_TAIL:
                    if (kind == ctds_pkg::TK_SEMICOLON)
                    begin
                        mode_next = ctds_pkg::MODE_IDLE;
                    end
                ctds_pkg::MODE_ID_PRE, ctds_pkg::MODE_ID_POST, ctds_pkg::MODE_GL_BODY:
                    if (kind == ctds_pkg::TK_SEMICOLON)
                    begin
                        mode_next = ctds_pkg::MODE_IDLE;
                    end
                    else if (kind == ctds_pkg::TK_EQ)
                    begin
                        mode_next = ctds_pkg::MODE_GL_BODY;
                    end
                    else if ((kind == ctds_pkg::TK_LPAREN)
                             && (mode_reg == ctds_pkg::MODE_ID_PRE))
                    begin
                        mode_next = ctds_pkg::MODE_ID_POST;
                    end
                    else if ((kind == ctds_pkg::TK_LBRACE)
                             && (mode_reg == ctds_pkg::MODE_ID_POST))
                    begin
                        nest_next = NB'(1);
                        mode_next = ctds_pkg::MODE_FN_BODY;
                    end
                ctds_pkg::MODE_FN_BODY:
                    if (kind == ctds_pkg::TK_LBRACE)
                    begin
                        nest_next = (&nest_reg) ? nest_reg : nest_reg + NB'(1);
                    end
                    else if (kind == ctds_pkg::TK_RBRACE)
                    begin
                        nest_next = nest_reg - NB'(1);
                        if (nest_reg == NB'(1))
                        begin
                            mode_next = ctds_pkg::MODE_IDLE;
                        end
                    end
                default:
                    mode_next = mode_reg;
            endcase

            // Top-level handling of the token overrides the above
            if (do_top)
            begin
                mode_next = ctds_pkg::MODE_IDLE;
                unique case (kind)
                    ctds_pkg::TK_DEFINE, ctds_pkg::TK_PRAGMA,
                    ctds_pkg::TK_INCLUDE, ctds_pkg::TK_ERROR_DIR:
                    begin
                        pending_next  = (kind == ctds_pkg::TK_DEFINE) ? ctds_pkg::CAT_DEFINE
                                      : (kind == ctds_pkg::TK_PRAGMA) ? ctds_pkg::CAT_PRAGMA
                                                                      : ctds_pkg::CAT_INCLUDE;
                        rs_index_next = idx;
                        rs_line_next  = line;
                        tracked_next  = line;
                        mode_next     = ctds_pkg::MODE_LINE;
                    end
                    ctds_pkg::TK_IF, ctds_pkg::TK_IFDEF, ctds_pkg::TK_IFNDEF:
                    begin
                        rs_index_next = idx;
                        rs_line_next  = line;
                        nest_next     = NB'(1);
                        mode_next     = ctds_pkg::MODE_IF;
                    end
                    ctds_pkg::TK_TYPEDEF:
                    begin
                        rs_index_next = idx;
                        rs_line_next  = line;
                        mode_next     = ctds_pkg::MODE_TD_FIRST;
                    end
                    ctds_pkg::TK_ENUM, ctds_pkg::TK_STRUCT:
                    begin
                        pending_next = (kind == ctds_pkg::TK_ENUM) ? ctds_pkg::CAT_ENUM
                                                                   : ctds_pkg::CAT_STRUCT;
                        mode_next    = ctds_pkg::MODE_SE_IDENT;
                    end
                    ctds_pkg::TK_IDENT:
                    begin
                        rs_index_next = idx;
                        rs_line_next  = line;
                        mode_next     = ctds_pkg::MODE_ID_PRE;
                    end
                    default:
                        mode_next = ctds_pkg::MODE_IDLE;
                endcase
            end

            if (eof_hit || fail_hit)
            begin
                mode_next = ctds_pkg::MODE_IDLE;
            end
            if (fail_hit)
            begin
                halted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ctds_pkg::MODE_IDLE;
            nest_reg       <= '0;
            rs_index_reg   <= '0;
            rs_line_reg    <= '0;
            tracked_reg    <= '0;
            prev_index_reg <= '0;
            prev_line_reg  <= '0;
            pending_reg    <= ctds_pkg::CAT_DEFINE;
            halted_reg     <= 1'b0;
        end
        else if (s_accept && !halted_reg)
        begin
            mode_reg       <= mode_next;
            nest_reg       <= nest_next;
            rs_index_reg   <= rs_index_next;
            rs_line_reg    <= rs_line_next;
            tracked_reg    <= tracked_next;
            prev_index_reg <= idx;
            prev_line_reg  <= line;
            pending_reg    <= pending_next;
            halted_reg     <= halted_next;
        end
    end

    // Result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + (s_accept ? ctds_pkg::PTR_BITS'(n_res) : '0);
            rd_ptr_reg <= rd_ptr_reg + ctds_pkg::PTR_BITS'(m_accept);
            count_reg  <= count_reg + (s_accept ? ctds_pkg::CNT_BITS'(n_res) : '0)
                          - ctds_pkg::CNT_BITS'(m_accept);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (s_accept && (n_res == 2'd2))
        begin
            fifo_reg[wr_ptr_reg + ctds_pkg::PTR_BITS'(1)] <= res1;
        end
    end

    ctds_pkg::result_t head;
    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tlast = head.last;
    assign m_tdata = {4'd0, head.close_line, head.end_index, head.start_line,
                      head.start_index, head.category};

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ctds_pkg::CNT_BITS'(ctds_pkg::FIFO_DEPTH))
        else $error("result queue over-filled");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (mode_reg == ctds_pkg::MODE_IDLE))
        else $error("halted with an open record");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && halted_reg && !m_accept) |=> $stable(count_reg))
        else $error("record produced while halted");

endmodule

`default_nettype wire
